>>> rtl/tlnf_pkg.sv
// Package for the text line number filter: character codes, config register
// indexes and the run descriptor passed from the control stage to the emitter.
// No dependencies.
`timescale 1ns / 1ps

package tlnf_pkg;

    // line counter field width and its hard ceiling
    localparam int unsigned COUNT_W   = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // config port index width
    localparam int unsigned CFG_IDX_W = 3;

    // character codes
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_CTRL_TOP  = 8'h20;
    localparam logic [7:0] CH_CARET_OFS = 8'h40;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_NONBLANK  = 3'd0,
        CFG_NUMBER_ALL       = 3'd1,
        CFG_SQUEEZE_BLANK    = 3'd2,
        CFG_SHOW_TABS        = 3'd3,
        CFG_SHOW_ENDS        = 3'd4,
        CFG_SHOW_NONPRINTING = 3'd5
    } cfg_idx_t;

    // one run of output bytes, minus the line number digits
    typedef struct packed {
        logic       numbered;   // line number and tab go first
        logic       two_tail;   // byte is shown as two bytes
        logic [7:0] tail0;
        logic [7:0] tail1;
    } desc_t;

endpackage

>>> rtl/text_line_number_filter.sv
// Top level of the text line number filter: config port, control stage and
// byte emitter. Uses tlnf_pkg, tlnf_ctrl and tlnf_emit.
//
//   channel   handshake              payload
//   -------   --------------------   ----------------------------
//   input     in_valid / in_stall    data_byte, new_file
//   output    out_valid / out_stall  out_byte, last_of_run
//   config    cfg_we (no handshake)  cfg_index, cfg_data
//
// One input byte is taken per cycle when its run is a single output byte and
// the output does not stall; a byte that expands into up to NUMBER_DIGITS+3
// bytes is held until the emitter, which sends one byte per beat, frees it.
// A squeezed blank line is taken without a run and gives no output.
// Reset (rst_n low) clears the config, sets line start and zeroes the counter.
// A stall on the output holds the output register; the input stalls once the
// emitter's descriptor cannot be freed in the same cycle.
`timescale 1ns / 1ps

module text_line_number_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tlnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            new_file,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run
);
    import tlnf_pkg::*;

    logic                       desc_ready;
    logic                       desc_push;
    desc_t                      desc;
    logic [4*NUMBER_DIGITS-1:0] digits;

    // line state and run descriptor
    tlnf_ctrl #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .new_file   (new_file),
        .desc_ready (desc_ready),
        .desc_push  (desc_push),
        .desc       (desc),
        .digits     (digits)
    );

    // byte serializer and output register
    tlnf_emit #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_push   (desc_push),
        .desc        (desc),
        .digits      (digits),
        .desc_ready  (desc_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

>>> rtl/tlnf_ctrl.sv
// Control stage of the text line number filter: config registers, line state,
// decimal line counter and the per-beat run descriptor. Uses tlnf_pkg.
`timescale 1ns / 1ps

module tlnf_ctrl #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tlnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            new_file,
    input  logic                            desc_ready,
    output logic                            desc_push,
    output tlnf_pkg::desc_t                 desc,
    output logic [4*NUMBER_DIGITS-1:0]      digits
);
    import tlnf_pkg::*;

    // counter ceiling: 10^digits - 1, capped at the field maximum
    localparam logic [63:0] TEN   = 64'd10;
    localparam logic [63:0] POW   = TEN ** NUMBER_DIGITS;
    localparam logic [63:0] LIM64 = ((POW - 64'd1) > 64'(COUNT_MAX)) ?
                                    64'(COUNT_MAX) : (POW - 64'd1);
    localparam logic [COUNT_W-1:0] LIMIT = LIM64[COUNT_W-1:0];

    logic nb_reg, na_reg, sq_reg, st_reg, se_reg, sv_reg;
    logic at_line_start_reg, at_line_start_next;
    logic blank_seen_reg, blank_seen_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [4*NUMBER_DIGITS-1:0] bcd_reg, bcd_next;

    logic als_cur, bs_cur;
    logic [COUNT_W-1:0] count_cur;
    logic [4*NUMBER_DIGITS-1:0] bcd_cur, bcd_inc;
    logic is_nl, is_ctrl, squeeze, numbered, accept;
    logic carry;
    logic [3:0] dig;

    assign in_stall = !desc_ready;
    assign accept   = in_valid && !in_stall;

    // config writes, out-of-range indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg <= 1'b0;
            na_reg <= 1'b0;
            sq_reg <= 1'b0;
            st_reg <= 1'b0;
            se_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUMBER_NONBLANK:  nb_reg <= cfg_data;
                CFG_NUMBER_ALL:       na_reg <= cfg_data;
                CFG_SQUEEZE_BLANK:    sq_reg <= cfg_data;
                CFG_SHOW_TABS:        st_reg <= cfg_data;
                CFG_SHOW_ENDS:        se_reg <= cfg_data;
                CFG_SHOW_NONPRINTING: sv_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // line state as seen by this beat, file start applied first
    always_comb
    begin
        als_cur   = new_file | at_line_start_reg;
        bs_cur    = new_file ? 1'b0 : blank_seen_reg;
        count_cur = new_file ? '0 : count_reg;
        bcd_cur   = new_file ? '0 : bcd_reg;
    end

    // decimal increment: a digit steps when all lower digits are nine
    always_comb
    begin
        carry = 1'b1;
        dig   = '0;
        for (int k = 0; k < NUMBER_DIGITS; k++)
        begin
            dig = bcd_cur[4*k +: 4];
            if (carry)
                bcd_inc[4*k +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
            else
                bcd_inc[4*k +: 4] = dig;
            carry = carry && (dig == 4'd9);
        end
    end

    // line decisions and shown form of the byte
    always_comb
    begin
        is_nl    = (data_byte == CH_NL);
        is_ctrl  = ((data_byte < CH_CTRL_TOP) || (data_byte == CH_DEL)) &&
                   (data_byte != CH_TAB) && !is_nl;
        squeeze  = als_cur && is_nl && sq_reg && bs_cur;
        numbered = als_cur && !squeeze && (nb_reg ? !is_nl : na_reg);

        blank_seen_next    = als_cur ? (is_nl && sq_reg) : bs_cur;
        at_line_start_next = is_nl;

        if (numbered && (count_cur < LIMIT))
        begin
            count_next = count_cur + COUNT_W'(1);
            bcd_next   = bcd_inc;
        end
        else
        begin
            count_next = count_cur;
            bcd_next   = bcd_cur;
        end

        desc.numbered = numbered;
        if (is_nl && se_reg)
        begin
            desc.two_tail = 1'b1;
            desc.tail0    = CH_DOLLAR;
            desc.tail1    = data_byte;
        end
        else if ((data_byte == CH_TAB) && st_reg)
        begin
            desc.two_tail = 1'b1;
            desc.tail0    = CH_CARET;
            desc.tail1    = CH_I;
        end
        else if (sv_reg && is_ctrl)
        begin
            desc.two_tail = 1'b1;
            desc.tail0    = CH_CARET;
            desc.tail1    = {1'b0, data_byte[6:0] + CH_CARET_OFS[6:0]};
        end
        else
        begin
            desc.two_tail = 1'b0;
            desc.tail0    = data_byte;
            desc.tail1    = data_byte;
        end
    end

    assign desc_push = accept && !squeeze;
    assign digits    = bcd_next;

    // line state, updated on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            blank_seen_reg    <= 1'b0;
            count_reg         <= '0;
            bcd_reg           <= '0;
        end
        else if (accept)
        begin
            at_line_start_reg <= at_line_start_next;
            blank_seen_reg    <= blank_seen_next;
            count_reg         <= count_next;
            bcd_reg           <= bcd_next;
        end
    end

endmodule

>>> rtl/tlnf_emit.sv
// Emitter of the text line number filter: holds one run descriptor and sends
// its bytes one per beat through the output register. Uses tlnf_pkg.
`timescale 1ns / 1ps

module tlnf_emit #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        desc_push,
    input  tlnf_pkg::desc_t             desc,
    input  logic [4*NUMBER_DIGITS-1:0]  digits,
    output logic                        desc_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic                        last_of_run
);
    import tlnf_pkg::*;

    localparam int PW = $clog2(NUMBER_DIGITS + 3);
    localparam logic [PW-1:0] POS_TAB  = PW'(NUMBER_DIGITS);
    localparam logic [PW-1:0] POS_TAIL = PW'(NUMBER_DIGITS + 1);

    logic                       desc_valid_reg;
    desc_t                      desc_reg;
    logic [4*NUMBER_DIGITS-1:0] digits_reg;
    logic [PW-1:0]              pos_reg, pos_next;
    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg, byte_next;
    logic                       last_reg;

    logic [PW-1:0] tail_base, last_pos, tpos;
    logic          is_last, can_emit, emit;
    logic          high_zero;
    logic [7:0]    disp [NUMBER_DIGITS];
    logic [7:0]    dig_byte;

    // run length and tail position
    always_comb
    begin
        tail_base = desc_reg.numbered ? POS_TAIL : '0;
        last_pos  = tail_base + (desc_reg.two_tail ? PW'(1) : PW'(0));
        tpos      = pos_reg - tail_base;
        is_last   = (pos_reg == last_pos);
    end

    assign can_emit   = !out_valid_reg || !out_stall;
    assign emit       = desc_valid_reg && can_emit;
    assign desc_ready = !desc_valid_reg || (emit && is_last);
    assign pos_next   = pos_reg + PW'(1);

    // digit bytes, leading zeros shown as spaces except the units digit
    always_comb
    begin
        high_zero = 1'b1;
        for (int k = NUMBER_DIGITS - 1; k >= 0; k--)
        begin
            high_zero = high_zero && (digits_reg[4*k +: 4] == 4'd0);
            if (high_zero && (k != 0))
                disp[k] = CH_SPACE;
            else
                disp[k] = CH_ZERO | {4'd0, digits_reg[4*k +: 4]};
        end
    end

    // pick the digit for this position, most significant first
    always_comb
    begin
        dig_byte = CH_SPACE;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (pos_reg == PW'(i))
                dig_byte = disp[NUMBER_DIGITS - 1 - i];
        end
    end

    // byte for this position
    always_comb
    begin
        if (desc_reg.numbered && (pos_reg < POS_TAB))
            byte_next = dig_byte;
        else if (desc_reg.numbered && (pos_reg == POS_TAB))
            byte_next = CH_TAB;
        else if (tpos == '0)
            byte_next = desc_reg.tail0;
        else
            byte_next = desc_reg.tail1;
    end

    // descriptor register and run position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else if (desc_ready)
        begin
            desc_valid_reg <= desc_push;
            pos_reg        <= '0;
        end
        else if (emit)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_ready && desc_push)
        begin
            desc_reg   <= desc;
            digits_reg <= digits;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (can_emit)
            out_valid_reg <= desc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_next;
            last_reg     <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

>>> rtl/tlnf_checker.sv
// Port-level checks for the text line number filter, bound to the top level.
// Depends only on the top level's handshake and payload ports.
`timescale 1ns / 1ps

module tlnf_checker #(
    parameter int NUMBER_DIGITS = 6
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [7:0]                      data_byte,
    input logic                            new_file,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [7:0]                      out_byte,
    input logic                            last_of_run
);

    localparam int RW = $clog2(NUMBER_DIGITS + 3);
    localparam logic [RW-1:0] RUN_MAX = RW'(NUMBER_DIGITS + 2);

    logic [RW-1:0] run_cnt_reg;

    // bytes of the current run already taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_cnt_reg <= '0;
        else if (out_valid && !out_stall)
            run_cnt_reg <= last_of_run ? '0 : run_cnt_reg + RW'(1);
    end

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(new_file))
        else $error("input beat changed while stalled");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
        else $error("output beat changed while stalled");

    // a run continues without a gap once started
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside an output run");

    // no run is longer than number, tab and two shown bytes
    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |-> run_cnt_reg < RUN_MAX)
        else $error("output run too long");

    // an empty output side never holds back the input with nothing queued
    a_out_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> out_valid)
        else $error("input stalled but no output followed");

endmodule

bind text_line_number_filter tlnf_checker #(
    .NUMBER_DIGITS (NUMBER_DIGITS)
) u_tlnf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .new_file    (new_file),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
);
